>>> sv/ccur_pkg.sv
`timescale 1ns / 1ps

package ccur_pkg;

  // Control bytes recognized by the console.
  localparam logic [7:0] CH_BEL   = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Configuration register indexes.
  localparam logic [1:0] REG_GLYPH_SCALE = 2'd0;
  localparam logic [1:0] REG_COLUMNS     = 2'd1;
  localparam logic [1:0] REG_ROWS        = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  // One quotient bit per step over the 9-bit column.
  localparam int DIV_STEPS   = 9;

  typedef enum logic [1:0] {
    OP_GLYPH  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_NEWLINE,
    CLS_TAB,
    CLS_BACKSPACE,
    CLS_CR,
    CLS_FF,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] code;
  } q_item_t;

  // Effective (clamped) screen settings.
  typedef struct packed {
    logic [4:0] scale;
    logic [7:0] cols;
    logic [7:0] rows;
  } cfg_t;

endpackage

>>> sv/ccur_front.sv
`timescale 1ns / 1ps

module ccur_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  output logic              push,
  output ccur_pkg::q_item_t push_item,
  input  logic              full
);
  import ccur_pkg::*;

  cls_t cls;

  always_comb begin
    unique case (char_code) inside
      CH_LF:         cls = CLS_NEWLINE;
      CH_TAB:        cls = CLS_TAB;
      CH_BS:         cls = CLS_BACKSPACE;
      CH_CR:         cls = CLS_CR;
      CH_FF:         cls = CLS_FF;
      CH_BEL, CH_VT: cls = CLS_NONE;
      default:       cls = CLS_PRINT;
    endcase
  end

  assign in_stall       = full;
  assign push           = in_valid && !full;
  assign push_item.cls  = cls;
  assign push_item.code = char_code;

endmodule

>>> sv/ccur_queue.sv
`timescale 1ns / 1ps

module ccur_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ccur_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output ccur_pkg::q_item_t head
);
  import ccur_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  q_item_t          mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  assign full  = (count == CntW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

endmodule

>>> sv/ccur_back.sv
`timescale 1ns / 1ps

module ccur_back #(
  parameter int TAB_WIDTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ccur_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  ccur_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        op,
  output logic [7:0]        cell_col,
  output logic [7:0]        cell_row,
  output logic [15:0]       pixel_x,
  output logic [15:0]       pixel_y,
  output logic [7:0]        glyph,
  output logic              last
);
  import ccur_pkg::*;

  typedef enum logic [1:0] {ST_FETCH, ST_WRAP, ST_DIV, ST_CURSOR} state_t;

  // Reciprocal of the tab width, exact for any 8-bit column.
  localparam int TabRecip = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int DivCntW  = $clog2(DIV_STEPS);

  state_t               state;
  logic [8:0]           cur_col;
  logic [9:0]           cur_row;
  logic [7:0]           tab_q;
  logic [8:0]           div_rem;
  logic [8:0]           div_quo;
  logic [DivCntW-1:0]   div_cnt;

  op_t                  out_op;
  logic [7:0]           out_col;
  logic [7:0]           out_row;
  logic [15:0]          out_px;
  logic [15:0]          out_py;
  logic [7:0]           out_glyph;
  logic                 out_last;

  logic                 out_free;
  logic                 out_load;
  logic [12:0]          mult_x;
  logic [11:0]          mult_y;
  logic [15:0]          pix_x;
  logic [15:0]          pix_y;
  logic [23:0]          tab_prod;
  logic [8:0]           tab_stop;

  logic                 first_emit;
  logic                 first_at;
  op_t                  first_op;
  logic [7:0]           first_glyph;
  logic [8:0]           col_t;
  logic [9:0]           row_t;

  logic [8:0]           cols9;
  logic                 need_div;
  logic                 wrap;
  logic [8:0]           col_w;
  logic [9:0]           row_w;
  logic                 need_scroll;
  logic [9:0]           row_f;

  logic [8:0]           trial;
  logic                 take;
  logic [8:0]           rem_step;
  logic [8:0]           quo_step;

  assign out_free = !out_valid || !out_stall;

  // Pixel origin of the cell at the cursor registers.
  assign mult_x = 13'(cur_col[7:0]) * 13'(cfg.scale);
  assign mult_y = 12'(cur_row[7:0]) * 12'(cfg.scale);
  assign pix_x  = {mult_x, 3'b000};
  assign pix_y  = {mult_y, 4'b0000};

  // tab_q holds the column divided by the tab width, refreshed while the
  // cursor block waits, so the tab stop needs no divide at fetch time.
  assign tab_prod = 24'(cur_col[7:0]) * 24'(TabRecip);
  assign tab_stop = 9'((int'(tab_q) + 1) * TAB_WIDTH);

  always_comb begin
    first_emit  = 1'b1;
    first_at    = 1'b1;
    first_op    = OP_GLYPH;
    first_glyph = CH_SPACE;
    col_t       = cur_col;
    row_t       = cur_row;
    unique case (q_item.cls)
      CLS_PRINT: begin
        first_glyph = q_item.code;
        col_t       = cur_col + 9'd1;
      end
      CLS_NEWLINE: begin
        col_t = '0;
        row_t = cur_row + 10'd1;
      end
      CLS_TAB: begin
        col_t = tab_stop;
      end
      CLS_BACKSPACE: begin
        first_emit = (cur_col != '0);
        if (cur_col != '0) begin
          col_t = cur_col - 9'd1;
        end
      end
      CLS_CR: begin
        col_t = '0;
      end
      CLS_FF: begin
        first_at    = 1'b0;
        first_op    = OP_CLEAR;
        first_glyph = '0;
        col_t       = '0;
        row_t       = '0;
      end
      CLS_NONE: begin
        first_emit = 1'b0;
      end
      default: begin
        first_emit = 1'b0;
      end
    endcase
  end

  // A column under twice the width wraps by one subtraction; anything
  // further out goes through the divider.
  assign cols9       = {1'b0, cfg.cols};
  assign need_div    = (cur_col >= {cfg.cols, 1'b0});
  assign wrap        = (cur_col >= cols9);
  assign col_w       = wrap ? cur_col - cols9 : cur_col;
  assign row_w       = wrap ? cur_row + 10'd1 : cur_row;
  assign need_scroll = (row_w >= {2'b00, cfg.rows});
  assign row_f       = need_scroll ? {2'b00, cfg.rows - 8'd1} : row_w;

  assign trial    = {div_rem[7:0], div_quo[8]};
  assign take     = (trial >= cols9);
  assign rem_step = take ? trial - cols9 : trial;
  assign quo_step = {div_quo[7:0], take};

  assign q_pop = (state == ST_FETCH) && q_valid && (!first_emit || out_free);

  // A new command is loaded into the output register this cycle.
  assign out_load = (q_pop && first_emit) ||
                    (state == ST_WRAP && !need_div && need_scroll && out_free) ||
                    (state == ST_CURSOR && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FETCH;
      cur_col   <= '0;
      cur_row   <= '0;
      tab_q     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_FETCH: begin
          if (q_pop) begin
            cur_col <= col_t;
            cur_row <= row_t;
            if (first_emit) begin
              out_valid <= 1'b1;
              out_op    <= first_op;
              out_col   <= first_at ? cur_col[7:0] : '0;
              out_row   <= first_at ? cur_row[7:0] : '0;
              out_px    <= first_at ? pix_x : '0;
              out_py    <= first_at ? pix_y : '0;
              out_glyph <= first_glyph;
              out_last  <= 1'b0;
            end
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (need_div) begin
            div_rem <= '0;
            div_quo <= cur_col;
            div_cnt <= '0;
            state   <= ST_DIV;
          end else if (!need_scroll || out_free) begin
            cur_col <= col_w;
            cur_row <= row_f;
            if (need_scroll) begin
              out_valid <= 1'b1;
              out_op    <= OP_SCROLL;
              out_col   <= '0;
              out_row   <= '0;
              out_px    <= '0;
              out_py    <= '0;
              out_glyph <= '0;
              out_last  <= 1'b0;
            end
            state <= ST_CURSOR;
          end
        end
        ST_DIV: begin
          div_rem <= rem_step;
          div_quo <= quo_step;
          div_cnt <= div_cnt + DivCntW'(1);
          if (div_cnt == DivCntW'(DIV_STEPS - 1)) begin
            cur_col <= rem_step;
            cur_row <= cur_row + {1'b0, quo_step};
            state   <= ST_WRAP;
          end
        end
        ST_CURSOR: begin
          tab_q <= tab_prod[23:16];
          if (out_free) begin
            out_valid <= 1'b1;
            out_op    <= OP_CURSOR;
            out_col   <= cur_col[7:0];
            out_row   <= cur_row[7:0];
            out_px    <= pix_x;
            out_py    <= pix_y;
            out_glyph <= '0;
            out_last  <= 1'b1;
            state     <= ST_FETCH;
          end
        end
        default: begin
          state <= ST_FETCH;
        end
      endcase
    end
  end

  assign op       = out_op;
  assign cell_col = out_col;
  assign cell_row = out_row;
  assign pixel_x  = out_px;
  assign pixel_y  = out_py;
  assign glyph    = out_glyph;
  assign last     = out_last;

  a_last_on_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_op == OP_CURSOR)))
    else $error("last flag does not match the cursor block command");

  a_blank_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_op == OP_CLEAR || out_op == OP_SCROLL) |->
      out_col == '0 && out_row == '0 && out_px == '0 && out_py == '0 && out_glyph == '0)
    else $error("clear or scroll command carries nonzero cell fields");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_div_returns: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_cnt == DivCntW'(DIV_STEPS - 1) |=> state == ST_WRAP)
    else $error("divider did not hand back to the wrap step");

endmodule

>>> sv/text_console_cursor_engine_top.sv
// Character-cell console cursor engine.
// Input channel: one character byte per beat on char_code (in_valid/in_stall).
// Output channel: cell drawing commands (out_valid/out_stall) with op, target
// cell, pixel origin, glyph and a last flag on the final command of a character.
// Each character gives one to three commands, always ending in a cursor block.
// Characters pass through a four-entry queue into a sequencer that takes each
// character through its steps in order: first command, wrap and scroll, cursor
// block. It takes the next character only once the cursor block of the last one
// is loaded. A column that lands two or more screen widths out (after the column
// count was lowered) is wrapped by a bit-serial divider before the wrap step runs
// again. A stall on the output holds the current command and stops the sequencer
// at any step that loads a command; the queue keeps taking characters until it
// is full, then raises in_stall.
// Reset puts the cursor at column 0, row 0, empties the queue and sets scale 1,
// 80 columns and 25 rows. Write cfg_write/cfg_index/cfg_data only while idle.
`timescale 1ns / 1ps

module text_console_cursor_engine_top #(
  parameter int TAB_WIDTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  op,
  output logic [7:0]  cell_col,
  output logic [7:0]  cell_row,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [7:0]  glyph,
  output logic        last
);
  import ccur_pkg::*;

  logic [4:0] scale_reg;
  logic [7:0] cols_reg;
  logic [7:0] rows_reg;
  cfg_t       cfg;

  logic       push;
  q_item_t    push_item;
  logic       full;
  logic       q_pop;
  logic       q_valid;
  q_item_t    q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_reg <= 5'd1;
      cols_reg  <= 8'd80;
      rows_reg  <= 8'd25;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GLYPH_SCALE: scale_reg <= cfg_data[4:0];
        REG_COLUMNS:     cols_reg  <= cfg_data;
        REG_ROWS:        rows_reg  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are clamped to the nearest usable value.
  always_comb begin
    if (scale_reg == 5'd0) begin
      cfg.scale = 5'd1;
    end else if (scale_reg > 5'd16) begin
      cfg.scale = 5'd16;
    end else begin
      cfg.scale = scale_reg;
    end
    cfg.cols = (cols_reg < 8'd4) ? 8'd4 : cols_reg;
    cfg.rows = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
  end

  ccur_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  ccur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ccur_back #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .glyph     (glyph),
    .last      (last)
  );

endmodule

>>> dv/text_console_cursor_engine_top_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_engine_top_tb;
  import ccur_pkg::*;

  localparam int TAB_W  = 4;
  localparam int CELL_W = 8;
  localparam int CELL_H = 16;
  // The block decodes indexes 0 to 2 only; a write here must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    op_t         op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  glyph;
    logic        last;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  op;
  logic [7:0]  cell_col;
  logic [7:0]  cell_row;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  glyph;
  logic        last;

  logic [7:0]  pending_chars[$];
  cmd_t        expected_cmds[$];
  cmd_t        exp_cmd;
  int          mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Register copies as written, and the cursor as the console should hold it.
  int unsigned reg_scale = 1;
  int unsigned reg_cols = 80;
  int unsigned reg_rows = 25;
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;

  text_console_cursor_engine_top #(
    .TAB_WIDTH(TAB_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .glyph     (glyph),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_cmd(op_t kind, bit at_cursor, logic [7:0] g);
    cmd_t        c;
    int unsigned s;
    int unsigned col;
    int unsigned row;
    s = (reg_scale < 1) ? 1 : ((reg_scale > 16) ? 16 : reg_scale);
    col = at_cursor ? cur_col : 0;
    row = at_cursor ? cur_row : 0;
    c.op = kind;
    c.col = col[7:0];
    c.row = row[7:0];
    c.px = 16'(col * CELL_W * s);
    c.py = 16'(row * CELL_H * s);
    c.glyph = g;
    // The cursor block always closes the commands of a character.
    c.last = (kind == OP_CURSOR);
    expected_cmds.push_back(c);
  endfunction

  function automatic void console_apply_char(logic [7:0] c);
    int unsigned ncols;
    int unsigned nrows;
    ncols = (reg_cols < 4) ? 4 : reg_cols;
    nrows = (reg_rows < 1) ? 1 : reg_rows;
    case (c)
      CH_LF: begin
        queue_cmd(OP_GLYPH, 1'b1, CH_SPACE);
        cur_row++;
        cur_col = 0;
      end
      CH_TAB: begin
        queue_cmd(OP_GLYPH, 1'b1, CH_SPACE);
        cur_col = (cur_col / TAB_W + 1) * TAB_W;
      end
      CH_BS: begin
        if (cur_col > 0) begin
          queue_cmd(OP_GLYPH, 1'b1, CH_SPACE);
          cur_col--;
        end
      end
      CH_CR: begin
        queue_cmd(OP_GLYPH, 1'b1, CH_SPACE);
        cur_col = 0;
      end
      CH_VT, CH_BEL: ;
      CH_FF: begin
        cur_col = 0;
        cur_row = 0;
        queue_cmd(OP_CLEAR, 1'b0, 8'd0);
      end
      default: begin
        queue_cmd(OP_GLYPH, 1'b1, c);
        cur_col++;
      end
    endcase
    if (cur_col >= ncols) begin
      cur_row += cur_col / ncols;
      cur_col = cur_col % ncols;
    end
    if (cur_row >= nrows) begin
      cur_row = nrows - 1;
      queue_cmd(OP_SCROLL, 1'b0, 8'd0);
    end
    queue_cmd(OP_CURSOR, 1'b1, 8'd0);
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Input side: a character is predicted at the edge where its beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        console_apply_char(char_code);
      end
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          char_code <= pending_chars.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $error("command beat with nothing expected: op %0d col %0d row %0d",
                 op, cell_col, cell_row);
          mismatches++;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          check_field("op", 16'(exp_cmd.op), 16'(op));
          check_field("cell_col", 16'(exp_cmd.col), 16'(cell_col));
          check_field("cell_row", 16'(exp_cmd.row), 16'(cell_row));
          check_field("pixel_x", exp_cmd.px, pixel_x);
          check_field("pixel_y", exp_cmd.py, pixel_y);
          check_field("glyph", 16'(exp_cmd.glyph), 16'(glyph));
          check_field("last", 16'(exp_cmd.last), 16'(last));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic drain();
    @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_cmds.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_GLYPH_SCALE: reg_scale = data[4:0];
      REG_COLUMNS:     reg_cols = data;
      REG_ROWS:        reg_rows = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] scale, input logic [7:0] cols,
                           input logic [7:0] nrows);
    drain();
    // Let any divider pass settle before touching the registers.
    repeat (16) @(posedge clk);
    write_reg(REG_GLYPH_SCALE, scale);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, nrows);
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] ctrl[7];
    ctrl = '{CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    if ($urandom_range(0, 99) < 30) begin
      // Form feed homes the cursor, so keep it rarer than tab and line feed.
      if ($urandom_range(0, 3) == 0) return ctrl[$urandom_range(0, 6)];
      return ($urandom_range(0, 1) == 0) ? CH_TAB : CH_LF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] directed[$];
    logic [7:0] scale_v;
    logic [7:0] cols_v;
    logic [7:0] rows_v;
    int         half;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: printable extremes and every control code.
    directed = '{8'h41, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_BEL, CH_VT, CH_BS, CH_CR,
                 CH_BS, CH_TAB, CH_TAB, CH_LF, CH_FF};
    foreach (directed[i]) pending_chars.push_back(directed[i]);

    // Scale 0 with high bits set, too few columns, zero rows: a one-row screen.
    configure(8'hE0, 8'd2, 8'd0);
    directed = '{8'h78, 8'h79, 8'h7A, 8'h77, CH_TAB};
    foreach (directed[i]) pending_chars.push_back(directed[i]);

    // Largest scale, then shrink the screen under a cursor far to the right,
    // so that one character wraps over many rows and then scrolls with one command.
    configure(8'd31, 8'd255, 8'd255);
    repeat (8) pending_chars.push_back(CH_TAB);
    configure(8'd31, 8'd4, 8'd2);
    pending_chars.push_back(8'h51);

    drain();
    write_reg(REG_UNUSED, 8'hA5);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin scale_v = 8'd1; cols_v = 8'd4; rows_v = 8'd1; end
        1: begin scale_v = 8'd16; cols_v = 8'd255; rows_v = 8'd255; end
        default: begin
          scale_v = 8'($urandom_range(0, 31));
          cols_v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 12));
          rows_v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 6));
        end
      endcase
      configure(scale_v, cols_v, rows_v);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 56; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 56; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      half = $urandom_range(10, 38);
      for (int k = 0; k < 44; k++) begin
        // Hold the input back mid-phase until the output has fully caught up.
        if (k == half) drain();
        pending_chars.push_back(random_char());
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> text_console_cursor_engine_top.f
sv/ccur_pkg.sv
sv/ccur_front.sv
sv/ccur_queue.sv
sv/ccur_back.sv
sv/text_console_cursor_engine_top.sv
dv/text_console_cursor_engine_top_tb.sv
